### sv/swm_pkg.sv
// shared types and constants for the sliding window median block
package swm_pkg;

    localparam int VALUE_W = 31;

    typedef logic [VALUE_W-1:0] value_t;

    // value handed between neighboring cells, with its less-than flag
    typedef struct packed {
        value_t value;
        logic   lt;
    } link_t;

endpackage

### sv/swm_if.sv
// stream interfaces for the sample and median channels
interface swm_sample_if;
    logic                 valid;
    logic                 ready;
    swm_pkg::value_t      sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface swm_median_if;
    logic                 valid;
    logic                 ready;
    swm_pkg::value_t      median;

    modport source (output valid, output median, input ready);
    modport sink (input valid, input median, output ready);
endinterface

### sv/swm_cell.sv
// one cell: a delay line tap and one slot of the sorted window
module swm_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift_en,
    input  swm_pkg::value_t fresh,
    input  swm_pkg::value_t old,
    input  swm_pkg::value_t ring_in,
    output swm_pkg::value_t ring_out,
    input  swm_pkg::link_t  from_right,
    output swm_pkg::link_t  to_left,
    input  swm_pkg::link_t  from_left,
    output swm_pkg::link_t  to_right,
    output swm_pkg::value_t slot
);

    swm_pkg::value_t ring_reg;
    swm_pkg::value_t slot_reg;
    swm_pkg::value_t slot_next;
    swm_pkg::value_t kept;
    logic            below_old;
    logic            below_new;
    logic            kept_lt;

    // own compares; the new-value compare is shared with the left neighbor
    assign below_old = slot_reg < old;
    assign below_new = slot_reg < fresh;

    // slot after the old value is taken out: keep own or pull from the right
    assign kept    = below_old ? slot_reg : from_right.value;
    assign kept_lt = below_old ? below_new : from_right.lt;

    // insert: stay below the new value, take the new value, or pull from the left
    always_comb
    begin
        if (kept_lt)
        begin
            slot_next = kept;
        end
        else if (from_left.lt)
        begin
            slot_next = fresh;
        end
        else
        begin
            slot_next = from_left.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg <= '0;
            slot_reg <= '0;
        end
        else if (shift_en)
        begin
            ring_reg <= ring_in;
            slot_reg <= slot_next;
        end
    end

    assign ring_out       = ring_reg;
    assign slot           = slot_reg;
    assign to_left.value  = slot_reg;
    assign to_left.lt     = below_new;
    assign to_right.value = kept;
    assign to_right.lt    = kept_lt;

endmodule

### sv/sliding_window_median.sv
// a median is shown in the cycle after its sample transaction is accepted
// throughput: one sample per cycle unless stalled, all cells update in the same cycle
// a new sample is accepted whenever the median register is empty or being taken
// reset: asynchronous, clears the delay line and the sorted window to zero
// and empties the median register, so early medians include those zeros
module sliding_window_median
#(
    parameter int WINDOW_SIZE = 19
)
(
    input  logic                clk,
    input  logic                rst_n,
    swm_sample_if.sink          din,
    swm_median_if.source        dout
);

    localparam int MID = WINDOW_SIZE / 2;

    // per-cell wiring; left and right links each carry one extra entry for the chain ends
    swm_pkg::value_t ring   [WINDOW_SIZE];
    swm_pkg::value_t slots  [WINDOW_SIZE];
    swm_pkg::link_t  lefts  [WINDOW_SIZE+1];
    swm_pkg::link_t  rights [WINDOW_SIZE+1];

    logic            accept;
    logic            out_valid_reg;
    logic            out_valid_next;
    swm_pkg::value_t oldest;

    // a stalled median holds because no sample is taken until it drains
    assign din.ready = !out_valid_reg || dout.ready;
    assign accept    = din.valid && din.ready;

    // the sample leaving the window sits at the tail of the delay line
    assign oldest = ring[WINDOW_SIZE-1];

    // left end: everything to the left counts as below the new sample
    assign lefts[0].value = '0;
    assign lefts[0].lt    = 1'b1;

    // right end: nothing beyond the last slot is below the new sample
    assign rights[WINDOW_SIZE].value = '0;
    assign rights[WINDOW_SIZE].lt    = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_SIZE; gi++)
        begin : g_cell
            swm_pkg::value_t ring_feed;

            if (gi == 0)
            begin : g_head
                assign ring_feed = din.sample;
            end
            else
            begin : g_tap
                assign ring_feed = ring[gi-1];
            end

            swm_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .shift_en   (accept),
                .fresh      (din.sample),
                .old        (oldest),
                .ring_in    (ring_feed),
                .ring_out   (ring[gi]),
                .from_right (rights[gi+1]),
                .to_left    (rights[gi]),
                .from_left  (lefts[gi]),
                .to_right   (lefts[gi+1]),
                .slot       (slots[gi])
            );
        end
    endgenerate

    // median register is the middle slot itself; only its valid flag is kept here
    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign dout.valid  = out_valid_reg;
    assign dout.median = slots[MID];

endmodule

### bench/sliding_window_median_tb.sv
// self-checking testbench for the sliding window median block with a window tracking scoreboard

// keeps its own copy of the window and the medians still owed by the block
class median_tracker #(int DEPTH = 19);
    typedef swm_pkg::value_t value_t;

    value_t sorted_vals [DEPTH];
    value_t arrival [DEPTH];
    int     slot;
    value_t pending_medians [$];
    int     mismatches;

    function new();
        foreach (sorted_vals[k])
        begin
            sorted_vals[k] = '0;
            arrival[k]     = '0;
        end
        slot       = 0;
        mismatches = 0;
    endfunction

    // slide one sample into the window and queue the median it yields
    function void note_sample(value_t fresh);
        value_t old;
        int     pos;
        slot = (slot == DEPTH - 1) ? 0 : slot + 1;
        old  = arrival[slot];
        arrival[slot] = fresh;
        // lowest slot holding the outgoing value, last slot if none does
        pos = DEPTH - 1;
        for (int k = DEPTH - 1; k >= 0; k--)
        begin
            if (sorted_vals[k] == old)
                pos = k;
        end
        if (fresh < old)
        begin
            while (pos > 0 && fresh < sorted_vals[pos-1])
            begin
                sorted_vals[pos] = sorted_vals[pos-1];
                pos--;
            end
        end
        else
        begin
            while (pos < DEPTH - 1 && fresh > sorted_vals[pos+1])
            begin
                sorted_vals[pos] = sorted_vals[pos+1];
                pos++;
            end
        end
        sorted_vals[pos] = fresh;
        pending_medians.push_back(sorted_vals[DEPTH/2]);
    endfunction

    task report_mismatch(string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatches++;
    endtask

    task check_median(value_t got);
        value_t want;
        if (pending_medians.size() == 0)
            report_mismatch($sformatf("median %h with none expected", got));
        else
        begin
            want = pending_medians.pop_front();
            if (got !== want)
                report_mismatch($sformatf("median %h, expected %h", got, want));
        end
    endtask
endclass

module sliding_window_median_tb;
    typedef swm_pkg::value_t value_t;

    localparam int     WINDOW_SIZE  = 19;
    localparam int     HOLD_CYCLES  = 300;     // long receiver hold-off
    localparam int     HOLD_ITEMS   = 40;      // samples offered during the hold-off
    localparam int     PHASE_ITEMS  = 180;     // random samples per idling phase
    localparam int     DRAIN_CYCLES = 8;       // quiet cycles after the last median
    localparam int     LIMIT_CYCLES = 200000;  // run is declared hung beyond this
    localparam value_t MAX_VALUE    = '1;

    logic clk = 1'b0;
    logic rst_n;

    swm_sample_if din_if ();
    swm_median_if dout_if ();

    sliding_window_median #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    median_tracker #(WINDOW_SIZE) tracker;

    // idling odds in percent, changed per phase
    int idle_pct;
    int stall_pct;

    // hold-off requests from the stimulus, served by the receiver process
    int hold_requests;
    int holds_served;
    int hold_left;

    int cycle_count;

    // last window of samples sent, used to aim new samples at the outgoing one
    value_t recent_samples [WINDOW_SIZE];
    int     sent_count;

    // directed set: extremes, bit patterns, duplicates, and the last five
    // replace the first five with equal, larger and smaller values
    value_t directed_samples [24] = '{
        31'h7FFFFFFF, 31'h00000000, 31'h7FFFFFFF, 31'h00000001,
        31'h7FFFFFFE, 31'h40000000, 31'h2AAAAAAA, 31'h55555555,
        31'h3FFFFFFF, 31'h00000000, 31'h7FFFFFFF, 31'h12345678,
        31'h12345678, 31'h0000FFFF, 31'h7FFF0000, 31'h00000002,
        31'h7FFFFFFF, 31'h00000000, 31'h6DB6DB6D,
        31'h7FFFFFFF, 31'h7FFFFFFF, 31'h00000000, 31'h00000001,
        31'h00000000
    };

    // 8 unit clock, high then low
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("sliding_window_median verification failed");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off whenever one is requested
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            dout_if.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (holds_served != hold_requests)
        begin
            dout_if.ready <= 1'b0;
            hold_left     <= HOLD_CYCLES - 1;
            holds_served  <= hold_requests;
        end
        else
            dout_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    // transaction monitor: check outgoing medians, then predict from incoming samples
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (dout_if.valid && dout_if.ready)
                tracker.check_median(dout_if.median);
            if (din_if.valid && din_if.ready)
                tracker.note_sample(din_if.sample);
        end
    end

    // offer one sample, with random idle cycles first; returns at its accepting edge
    task automatic send_sample(input value_t v);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            din_if.valid <= 1'b0;
            @(negedge clk);
        end
        din_if.valid  <= 1'b1;
        din_if.sample <= v;
        do
            @(posedge clk);
        while (!(din_if.valid && din_if.ready));
        recent_samples[sent_count % WINDOW_SIZE] = v;
        sent_count++;
    endtask

    // stop offering and wait until every predicted median has come back
    task automatic wait_drained();
        @(negedge clk);
        din_if.valid <= 1'b0;
        while (tracker.pending_medians.size() != 0)
            @(negedge clk);
    endtask

    // random sample with a bias toward duplicates, extremes and the outgoing value
    function automatic value_t pick_sample();
        value_t v;
        value_t prev;
        prev = recent_samples[(sent_count + WINDOW_SIZE - 1) % WINDOW_SIZE];
        case ($urandom_range(0, 9))
            0, 1, 2: v = value_t'($urandom);
            3, 4:    v = value_t'($urandom_range(0, 15));
            // same value as the one about to leave the window
            5:       v = recent_samples[sent_count % WINDOW_SIZE];
            // close to the previous sample, wrapping at the extremes
            6:       v = prev + value_t'($urandom_range(0, 6)) - value_t'(3);
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       v = '0;
                    1:       v = MAX_VALUE;
                    2:       v = MAX_VALUE - value_t'(1);
                    default: v = value_t'(1);
                endcase
            end
            8:
            begin
                v = value_t'(1) << $urandom_range(0, swm_pkg::VALUE_W - 1);
                if ($urandom_range(0, 1))
                    v = ~v;
            end
            default: v = MAX_VALUE - value_t'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    initial
    begin
        int phase;

        tracker       = new();
        rst_n         = 1'b0;
        din_if.valid  = 1'b0;
        din_if.sample = '0;
        dout_if.ready = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        foreach (recent_samples[k])
            recent_samples[k] = '0;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed part, no idling, starting from the all-zero window
        foreach (directed_samples[k])
            send_sample(directed_samples[k]);

        // sender pauses until every median is back
        wait_drained();

        // receiver holds off for a long stretch while samples keep coming,
        // so the median register fills and the input stalls
        hold_requests <= hold_requests + 1;
        repeat (HOLD_ITEMS)
            send_sample(pick_sample());
        wait_drained();

        // idling phases: none, sender idle, receiver stalling, both
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  <= 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    idle_pct  <= 58;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct  <= 0;
                    stall_pct <= 58;
                end
                default:
                begin
                    idle_pct  <= 36;
                    stall_pct <= 36;
                end
            endcase
            repeat (PHASE_ITEMS)
                send_sample(pick_sample());
        end

        // all samples in: collect the remaining medians and watch for strays
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (tracker.mismatches == 0)
            $display("sliding_window_median verification clean");
        else
            $display("sliding_window_median verification failed");
        $finish;
    end

endmodule
